/* design/pbes_pkg.sv */
// shared types, codes and a helper function for the panel button and encoder scanner
package pbes_pkg;

   typedef enum logic [1:0] {
      ACT_POLL   = 2'd0,
      ACT_SET    = 2'd1,
      ACT_TOGGLE = 2'd2,
      ACT_ROTATE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PWR_NONE  = 2'd0,
      PWR_SET   = 2'd1,
      PWR_CLEAR = 2'd2
   } power_type;

   localparam logic [7:0] ALL_OUTPUTS = 8'hff;
   localparam int ENC_COUNT = 8;
   localparam int BTN_COUNT = 16;
   localparam logic signed [16:0] PEND_MAX = 17'sd32767;
   localparam logic signed [16:0] PEND_MIN = -17'sd32767;

   typedef struct packed {
      logic              rotate;
      logic [2:0]        index;
      logic signed [6:0] amount;
      logic              step;
      logic              group;
   } enc_cmd_type;

   function automatic logic [1:0] phase_code(input logic [1:0] phase);
      logic [1:0] code;
      case (phase)
         2'd0:    code = 2'b00;
         2'd1:    code = 2'b10;
         2'd2:    code = 2'b11;
         default: code = 2'b01;
      endcase
      return code;
   endfunction

endpackage

/* design/pbes_encoders.sv */
// eight encoder pending counts and quadrature phases with group code readout
module pbes_encoders (
   input  logic                   clock,
   input  logic                   reset,
   input  pbes_pkg::enc_cmd_type  cmd,
   output logic [7:0]             codes
);

   logic signed [15:0] pending_ff [pbes_pkg::ENC_COUNT];
   logic signed [15:0] pending_in [pbes_pkg::ENC_COUNT];
   logic [1:0]         phase_ff   [pbes_pkg::ENC_COUNT];
   logic [1:0]         phase_in   [pbes_pkg::ENC_COUNT];
   logic signed [16:0] sum        [pbes_pkg::ENC_COUNT];

   always_comb begin
      for (int i = 0; i < pbes_pkg::ENC_COUNT; i++) begin
         pending_in[i] = pending_ff[i];
         phase_in[i]   = phase_ff[i];
         sum[i]        = 17'(pending_ff[i]) + 17'(cmd.amount);
         if (cmd.rotate && cmd.index == 3'(i)) begin
            if (sum[i] > pbes_pkg::PEND_MAX) begin
               pending_in[i] = 16'(pbes_pkg::PEND_MAX);
            end else if (sum[i] < pbes_pkg::PEND_MIN) begin
               pending_in[i] = 16'(pbes_pkg::PEND_MIN);
            end else begin
               pending_in[i] = sum[i][15:0];
            end
         end
         if (cmd.step && cmd.group == 1'(i >> 2)) begin
            if (pending_ff[i] > 16'sd0) begin
               pending_in[i] = pending_ff[i] - 16'sd1;
               phase_in[i]   = phase_ff[i] - 2'd1;
            end else if (pending_ff[i] < 16'sd0) begin
               pending_in[i] = pending_ff[i] + 16'sd1;
               phase_in[i]   = phase_ff[i] + 2'd1;
            end
         end
      end
   end

   // codes of the selected group, after this transaction's step
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         codes[2*k +: 2] = pbes_pkg::phase_code(phase_in[{cmd.group, 2'(k)}]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbes_pkg::ENC_COUNT; i++) begin
            pending_ff[i] <= '0;
            phase_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < pbes_pkg::ENC_COUNT; i++) begin
            pending_ff[i] <= pending_in[i];
            phase_ff[i]   <= phase_in[i];
         end
      end
   end

endmodule

/* design/panel_button_encoder_scanner.sv */
// top level of the panel button and encoder scanner
//
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | tuser action, tdata port levels and event fields
//  rsp     | out | rsp_tvalid/rsp_tready | tdata handled, write valid, data, power action
//
//  one transaction per cycle unless the result stalls; each one passes through the input register
//  and is answered from the result register
//  state is updated as a transaction moves from the input to the result register
//  reset clears all buttons, counts, phases and the last seen write count
//  a stalled result holds the pipeline; ready returns as soon as the result is taken
module panel_button_encoder_scanner #(
   parameter int POWER_BUTTON = 0,
   parameter int POWER_BIT    = 0,
   parameter int BTN0_SEL_BIT = 1,
   parameter int BTN1_SEL_BIT = 2,
   parameter int ENC0_SEL_BIT = 3,
   parameter int ENC1_SEL_BIT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action
   input  logic [1:0]  req_tuser,
   // gp_direction, port_e_bits, e_write_count, item_index, pressed, rotate_amount, zero pad
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // handled, gp_write_valid, gp_data, power_action, zero pad
   output logic [15:0] rsp_tdata
);

   localparam logic [3:0] PWR_BTN_IDX = 4'(POWER_BUTTON);
   localparam logic [2:0] PWR_BIT_IDX = 3'(POWER_BIT);
   localparam logic [2:0] BTN0_IDX    = 3'(BTN0_SEL_BIT);
   localparam logic [2:0] BTN1_IDX    = 3'(BTN1_SEL_BIT);
   localparam logic [2:0] ENC0_IDX    = 3'(ENC0_SEL_BIT);
   localparam logic [2:0] ENC1_IDX    = 3'(ENC1_SEL_BIT);

   logic                    s1_valid_ff;
   pbes_pkg::action_type    action_ff;
   logic [7:0]              direction_ff;
   logic [7:0]              port_e_ff;
   logic [31:0]             write_count_ff;
   logic [3:0]              index_ff;
   logic                    pressed_ff;
   logic signed [6:0]       amount_ff;

   logic [pbes_pkg::BTN_COUNT-1:0] button_ff;
   logic [pbes_pkg::BTN_COUNT-1:0] button_in;
   logic [31:0]             last_count_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_data_ff;

   logic                    advance;
   logic                    fire;
   logic                    poll;
   logic                    count_changed;
   logic                    pwr_btn;
   logic                    pwr_bit;
   pbes_pkg::power_type     power;
   logic                    handled;
   logic [7:0]              gp_data;
   logic                    enc_read;
   logic                    enc_group;
   pbes_pkg::enc_cmd_type   enc_cmd;
   logic [7:0]              enc_codes;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign fire       = s1_valid_ff && advance;

   assign poll = fire && action_ff == pbes_pkg::ACT_POLL &&
                 direction_ff != pbes_pkg::ALL_OUTPUTS;
   assign count_changed = write_count_ff != last_count_ff;
   assign pwr_btn = button_ff[PWR_BTN_IDX];
   assign pwr_bit = port_e_ff[PWR_BIT_IDX];

   always_comb begin
      power = pbes_pkg::PWR_NONE;
      if (pwr_btn && !pwr_bit) begin
         power = pbes_pkg::PWR_SET;
      end else if (!pwr_btn && pwr_bit) begin
         power = pbes_pkg::PWR_CLEAR;
      end
   end

   // select decode, active low, fixed priority
   always_comb begin
      handled   = 1'b1;
      gp_data   = '0;
      enc_read  = 1'b0;
      enc_group = 1'b0;
      if (!port_e_ff[BTN0_IDX]) begin
         gp_data = button_ff[7:0];
      end else if (!port_e_ff[BTN1_IDX]) begin
         gp_data = button_ff[15:8];
      end else if (!port_e_ff[ENC0_IDX]) begin
         enc_read = 1'b1;
         gp_data  = enc_codes;
      end else if (!port_e_ff[ENC1_IDX]) begin
         enc_read  = 1'b1;
         enc_group = 1'b1;
         gp_data   = enc_codes;
      end else begin
         handled = 1'b0;
      end
   end

   always_comb begin
      enc_cmd.rotate = fire && action_ff == pbes_pkg::ACT_ROTATE && !index_ff[3];
      enc_cmd.index  = index_ff[2:0];
      enc_cmd.amount = amount_ff;
      enc_cmd.step   = poll && enc_read && count_changed;
      enc_cmd.group  = enc_group;
   end

   pbes_encoders u_encoders (
      .clock (clock),
      .reset (reset),
      .cmd   (enc_cmd),
      .codes (enc_codes)
   );

   always_comb begin
      button_in = button_ff;
      if (fire) begin
         case (action_ff)
            pbes_pkg::ACT_SET:    button_in[index_ff] = pressed_ff;
            pbes_pkg::ACT_TOGGLE: button_in[index_ff] = !button_ff[index_ff];
            default:              button_in = button_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         button_ff     <= '0;
         last_count_ff <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         button_ff <= button_in;
         if (poll) begin
            last_count_ff <= write_count_ff;
         end
      end
   end

   // input and result payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         action_ff      <= pbes_pkg::action_type'(req_tuser);
         direction_ff   <= req_tdata[7:0];
         port_e_ff      <= req_tdata[15:8];
         write_count_ff <= req_tdata[47:16];
         index_ff       <= req_tdata[51:48];
         pressed_ff     <= req_tdata[52];
         amount_ff      <= req_tdata[59:53];
      end
      if (fire) begin
         if (poll) begin
            rsp_data_ff <= {4'd0, power, (handled ? gp_data : 8'd0), handled, handled};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_unhandled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[0] |-> rsp_data_ff[9:1] == 9'd0)
      else $error("unhandled transaction carries data");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tready && !s1_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared without a transaction");

   a_count_on_poll: assert property (@(posedge clock) disable iff (reset)
      !poll |=> $stable(last_count_ff))
      else $error("write count recorded outside a poll");

   a_step_needs_read: assert property (@(posedge clock) disable iff (reset)
      enc_cmd.step |-> poll && handled && !enc_cmd.rotate)
      else $error("encoder step without an encoder read");

endmodule

/* sim/tb_top.sv */
// testbench for the panel button and encoder scanner, self-checking against its own predictor
`timescale 1ns / 100ps

module tb_top;

   localparam int POWER_BUTTON  = 0;
   localparam int POWER_BIT     = 0;
   localparam int BTN0_SEL_BIT  = 1;
   localparam int BTN1_SEL_BIT  = 2;
   localparam int ENC0_SEL_BIT  = 3;
   localparam int ENC1_SEL_BIT  = 4;
   localparam int PENDING_LIMIT = 32767;

   typedef struct {
      pbes_pkg::action_type act;
      logic [7:0]           dir;
      logic [7:0]           ebits;
      logic [31:0]          wc;
      logic [3:0]           idx;
      logic                 pr;
      logic signed [6:0]    amt;
   } panel_event_type;

   typedef struct {
      logic                handled;
      logic                wr_valid;
      logic [7:0]          data;
      pbes_pkg::power_type pwr;
   } port_answer_type;

   class panel_scan_checker_type;
      logic [15:0]     btn_level;
      int              pending[pbes_pkg::ENC_COUNT];
      logic [1:0]      phase[pbes_pkg::ENC_COUNT];
      logic [31:0]     last_wc;
      port_answer_type expected_answers[$];
      int              errors;

      function new();
         btn_level = '0;
         last_wc   = '0;
         errors    = 0;
         foreach (pending[i]) begin
            pending[i] = 0;
            phase[i]   = 2'd0;
         end
      endfunction

      function logic [1:0] gray_of(logic [1:0] ph);
         logic [1:0] code;
         case (ph)
            2'd0:    code = 2'b00;
            2'd1:    code = 2'b10;
            2'd2:    code = 2'b11;
            default: code = 2'b01;
         endcase
         return code;
      endfunction

      function logic [7:0] read_encoders(int base, bit stepping);
         logic [7:0] codes;
         int k;
         codes = '0;
         for (int i = 0; i < 4; i++) begin
            k = base + i;
            if (stepping) begin
               if (pending[k] > 0) begin
                  phase[k]   = phase[k] - 2'd1;
                  pending[k] = pending[k] - 1;
               end else if (pending[k] < 0) begin
                  phase[k]   = phase[k] + 2'd1;
                  pending[k] = pending[k] + 1;
               end
            end
            codes[2*i +: 2] = gray_of(phase[k]);
         end
         return codes;
      endfunction

      function void note_event(panel_event_type ev);
         port_answer_type ans;
         int              sum;
         bit              stepping;
         logic            pbtn;
         logic            pbit;
         ans = '{handled: 1'b0, wr_valid: 1'b0, data: 8'h00, pwr: pbes_pkg::PWR_NONE};
         case (ev.act)
            pbes_pkg::ACT_SET: begin
               btn_level[ev.idx] = ev.pr;
            end
            pbes_pkg::ACT_TOGGLE: begin
               btn_level[ev.idx] = ~btn_level[ev.idx];
            end
            pbes_pkg::ACT_ROTATE: begin
               if (ev.idx < 4'd8) begin
                  sum = pending[ev.idx[2:0]] + int'(ev.amt);
                  if (sum > PENDING_LIMIT) sum = PENDING_LIMIT;
                  if (sum < -PENDING_LIMIT) sum = -PENDING_LIMIT;
                  pending[ev.idx[2:0]] = sum;
               end
            end
            default: begin
               if (ev.dir != pbes_pkg::ALL_OUTPUTS) begin
                  stepping = (ev.wc != last_wc);
                  last_wc  = ev.wc;
                  pbtn     = btn_level[POWER_BUTTON];
                  pbit     = ev.ebits[POWER_BIT];
                  if (pbtn && !pbit) ans.pwr = pbes_pkg::PWR_SET;
                  else if (!pbtn && pbit) ans.pwr = pbes_pkg::PWR_CLEAR;
                  ans.handled = 1'b1;
                  if (!ev.ebits[BTN0_SEL_BIT]) ans.data = btn_level[7:0];
                  else if (!ev.ebits[BTN1_SEL_BIT]) ans.data = btn_level[15:8];
                  else if (!ev.ebits[ENC0_SEL_BIT]) ans.data = read_encoders(0, stepping);
                  else if (!ev.ebits[ENC1_SEL_BIT]) ans.data = read_encoders(4, stepping);
                  else ans.handled = 1'b0;
                  ans.wr_valid = ans.handled;
               end
            end
         endcase
         expected_answers.push_back(ans);
      endfunction

      function void check_answer(logic [15:0] rsp);
         port_answer_type ans;
         if (expected_answers.size() == 0) begin
            $error("unexpected response transaction %04h", rsp);
            errors++;
            return;
         end
         ans = expected_answers.pop_front();
         if (rsp[0] !== ans.handled) begin
            $error("handled mismatch: expected %0d, actual %0d", ans.handled, rsp[0]);
            errors++;
         end
         if (rsp[1] !== ans.wr_valid) begin
            $error("gp_write_valid mismatch: expected %0d, actual %0d", ans.wr_valid, rsp[1]);
            errors++;
         end
         if (rsp[9:2] !== ans.data) begin
            $error("gp_data mismatch: expected %02h, actual %02h", ans.data, rsp[9:2]);
            errors++;
         end
         if (rsp[11:10] !== ans.pwr) begin
            $error("power_action mismatch: expected %0d, actual %0d", ans.pwr, rsp[11:10]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [31:0] stall_pattern = '1;
   int          pattern_left  = 0;
   int          burst_left    = 0;
   logic [31:0] recent_wc     = '0;
   panel_scan_checker_type scan_check = new();

   panel_button_encoder_scanner #(
      .POWER_BUTTON (POWER_BUTTON),
      .POWER_BIT    (POWER_BIT),
      .BTN0_SEL_BIT (BTN0_SEL_BIT),
      .BTN1_SEL_BIT (BTN1_SEL_BIT),
      .ENC0_SEL_BIT (ENC0_SEL_BIT),
      .ENC1_SEL_BIT (ENC1_SEL_BIT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver stalls follow a rotating pattern, renewed whenever its countdown runs out
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
         pattern_left  <= 64;
      end else begin
         stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
         pattern_left  <= pattern_left - 1;
      end
      rsp_tready <= stall_pattern[0];
   end

   always @(posedge clock) begin
      panel_event_type ev;
      if (!reset && req_tvalid && req_tready) begin
         ev.act   = pbes_pkg::action_type'(req_tuser);
         ev.dir   = req_tdata[7:0];
         ev.ebits = req_tdata[15:8];
         ev.wc    = req_tdata[47:16];
         ev.idx   = req_tdata[51:48];
         ev.pr    = req_tdata[52];
         ev.amt   = req_tdata[59:53];
         scan_check.note_event(ev);
      end
      if (!reset && rsp_tvalid && rsp_tready) scan_check.check_answer(rsp_tdata);
   end

   function automatic panel_event_type make_event(pbes_pkg::action_type a, logic [7:0] dir,
                                                  logic [7:0] ebits, logic [31:0] wc,
                                                  logic [3:0] idx, logic pr,
                                                  logic signed [6:0] amt);
      panel_event_type ev;
      ev = '{act: a, dir: dir, ebits: ebits, wc: wc, idx: idx, pr: pr, amt: amt};
      return ev;
   endfunction

   function automatic panel_event_type random_event();
      panel_event_type ev;
      int              pick;
      pick     = $urandom_range(0, 9);
      ev.act   = (pick < 4) ? pbes_pkg::ACT_POLL :
                 (pick < 6) ? pbes_pkg::ACT_SET :
                 (pick < 8) ? pbes_pkg::ACT_TOGGLE : pbes_pkg::ACT_ROTATE;
      ev.dir   = ($urandom_range(0, 9) == 0) ? pbes_pkg::ALL_OUTPUTS : 8'($urandom);
      ev.ebits = 8'($urandom);
      pick     = $urandom_range(0, 5);
      if (pick < 5) ev.ebits[4:1] = 4'hf;
      if (pick < 4) ev.ebits[pick + 1] = 1'b0;
      pick     = $urandom_range(0, 9);
      ev.wc    = (pick < 5) ? recent_wc : (pick < 8) ? recent_wc + 32'd1 : 32'($urandom);
      ev.idx   = 4'($urandom);
      if (ev.act == pbes_pkg::ACT_ROTATE && $urandom_range(0, 3) != 0) ev.idx[3] = 1'b0;
      ev.pr    = 1'($urandom);
      ev.amt   = 7'($urandom);
      return ev;
   endfunction

   task automatic send_event(panel_event_type ev);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      if (ev.act == pbes_pkg::ACT_POLL) recent_wc = ev.wc;
      req_tvalid <= 1'b1;
      req_tuser  <= ev.act;
      req_tdata  <= {4'h0, ev.amt, ev.pr, ev.idx, ev.wc, ev.ebits, ev.dir};
      do @(posedge clock); while (!req_tready);
   endtask

   // long run of large rotations on one encoder to drive its count into saturation
   task automatic saturate_encoder(logic [2:0] enc, logic signed [6:0] amt, int count);
      panel_event_type ev;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 15) begin
            ev = random_event();
            ev.act   = pbes_pkg::ACT_POLL;
            ev.dir   = 8'($urandom_range(0, 254));
            ev.ebits[4:1] = enc[2] ? 4'b0111 : 4'b1011;
            send_event(ev);
         end
         ev     = random_event();
         ev.act = pbes_pkg::ACT_ROTATE;
         ev.idx = {1'b0, enc};
         ev.amt = amt;
         send_event(ev);
      end
   endtask

   initial begin
      int drain;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no select, power bit high with button released
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'hff, 32'h0, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_SET, 8'h00, 8'h00, 32'h0, 4'd0, 1'b1, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_SET, 8'hff, 8'hff, 32'h0, 4'd15, 1'b1, -7'sd64));
      send_event(make_event(pbes_pkg::ACT_TOGGLE, 8'h55, 8'haa, 32'h0, 4'd7, 1'b0, 7'sd63));
      send_event(make_event(pbes_pkg::ACT_TOGGLE, 8'h00, 8'h00, 32'h0, 4'd8, 1'b1, 7'sd0));
      // all selects low, button group 0 wins
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'h00, 32'h0, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h0f, 8'hf9, 32'h0, 4'd0, 1'b0, 7'sd0));
      // data port all outputs, ignored
      send_event(make_event(pbes_pkg::ACT_POLL, 8'hff, 8'h00, 32'h5, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_ROTATE, 8'h00, 8'h00, 32'h0, 4'd0, 1'b0, 7'sd63));
      send_event(make_event(pbes_pkg::ACT_ROTATE, 8'h00, 8'h00, 32'h0, 4'd3, 1'b0, -7'sd64));
      send_event(make_event(pbes_pkg::ACT_ROTATE, 8'h00, 8'h00, 32'h0, 4'd5, 1'b0, 7'sd1));
      send_event(make_event(pbes_pkg::ACT_ROTATE, 8'h00, 8'h00, 32'h0, 4'd7, 1'b0, -7'sd1));
      send_event(make_event(pbes_pkg::ACT_ROTATE, 8'h00, 8'h00, 32'h0, 4'd12, 1'b0, 7'sd63));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'hf7, 32'h1, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'hf7, 32'h1, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'hfe, 8'hf6, 32'hffff_ffff, 4'd0, 1'b0,
                            7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'hef, 32'h2, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'hee, 32'h3, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_SET, 8'h00, 8'h00, 32'h0, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h80, 8'hfe, 32'h3, 4'd0, 1'b0, 7'sd0));
      send_event(make_event(pbes_pkg::ACT_POLL, 8'h00, 8'he1, 32'h4, 4'd0, 1'b0, 7'sd0));

      for (int i = 0; i < 400; i++) send_event(random_event());
      saturate_encoder(3'($urandom_range(0, 7)), 7'sd63, 540);
      for (int i = 0; i < 100; i++) send_event(random_event());
      saturate_encoder(3'($urandom_range(0, 7)), -7'sd64, 520);
      for (int i = 0; i < 300; i++) send_event(random_event());
      req_tvalid <= 1'b0;

      drain = 0;
      while (scan_check.expected_answers.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (scan_check.errors == 0 && scan_check.expected_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* panel_button_encoder_scanner.f */
design/pbes_pkg.sv
design/pbes_encoders.sv
design/panel_button_encoder_scanner.sv
sim/tb_top.sv
